@@ rtl/pstrr_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pstrr_pkg
// Shared types and codes for the process slot table with round-robin ring.
// ----------------------------------------------------------------------------
package pstrr_pkg;

   localparam int CMD_BITS = 3;
   localparam int SLOT_BITS = 7;
   localparam int GEN_PORT_BITS = 16;

   localparam logic [CMD_BITS-1:0] CMD_ALLOC  = 3'd0;
   localparam logic [CMD_BITS-1:0] CMD_CHECK  = 3'd1;
   localparam logic [CMD_BITS-1:0] CMD_RESUME = 3'd2;
   localparam logic [CMD_BITS-1:0] CMD_PAUSE  = 3'd3;
   localparam logic [CMD_BITS-1:0] CMD_EXIT   = 3'd4;
   localparam logic [CMD_BITS-1:0] CMD_TICK   = 3'd5;

   // link update sequence: one write per step
   localparam logic [2:0] WR_STEP_LAST = 3'd4;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_SCAN,
      ST_RD1,
      ST_RD2,
      ST_RD3,
      ST_WR,
      ST_FIN,
      ST_RESP
   } state_type;

   typedef struct packed {
      logic       load;
      logic       scan;
      logic       rd1;
      logic       rd2;
      logic       rd3;
      logic       wr;
      logic [2:0] wr_step;
      logic       fin;
   } ctrl_cmd_type;

   typedef struct packed {
      logic req_is_alloc;
      logic scan_free;
      logic scan_last;
   } dp_status_type;

endpackage

@@ rtl/pstrr_ctrl.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pstrr_ctrl
// Sequencer: slot scan, two link/generation read rounds, five link write
// steps, commit and response hold.
// ----------------------------------------------------------------------------
module pstrr_ctrl
   import pstrr_pkg::*;
(
   input  logic          clock,
   input  logic          reset,
   input  logic          req_valid,
   output logic          req_stall,
   output logic          rsp_valid,
   input  logic          rsp_stall,
   input  dp_status_type status,
   output ctrl_cmd_type  cmd
);

   state_type  state_ff, state_in;
   logic [2:0] step_ff, step_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         step_ff  <= 3'd0;
      end else begin
         state_ff <= state_in;
         step_ff  <= step_in;
      end
   end

   always_comb begin
      state_in = state_ff;
      step_in  = 3'd0;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               state_in = status.req_is_alloc ? ST_SCAN : ST_RD1;
            end
         end
         ST_SCAN: begin
            if (status.scan_free || status.scan_last) begin
               state_in = ST_RD1;
            end
         end
         ST_RD1: state_in = ST_RD2;
         ST_RD2: state_in = ST_RD3;
         ST_RD3: state_in = ST_WR;
         ST_WR: begin
            if (step_ff == WR_STEP_LAST) begin
               state_in = ST_FIN;
            end else begin
               step_in = step_ff + 3'd1;
            end
         end
         ST_FIN: state_in = ST_RESP;
         ST_RESP: begin
            if (!rsp_stall) begin
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_comb begin
      cmd         = '0;
      cmd.wr_step = step_ff;
      req_stall   = 1'b1;
      rsp_valid   = 1'b0;
      unique case (state_ff)
         ST_IDLE: begin
            req_stall = 1'b0;
            cmd.load  = req_valid;
         end
         ST_SCAN: cmd.scan = 1'b1;
         ST_RD1:  cmd.rd1 = 1'b1;
         ST_RD2:  cmd.rd2 = 1'b1;
         ST_RD3:  cmd.rd3 = 1'b1;
         ST_WR:   cmd.wr = 1'b1;
         ST_FIN:  cmd.fin = 1'b1;
         ST_RESP: rsp_valid = 1'b1;
         default: ;
      endcase
   end

endmodule

@@ rtl/pstrr_dpath.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pstrr_dpath
// Slot flags, generation and link memories, operand registers, link write
// decode and the response register.
// ----------------------------------------------------------------------------
module pstrr_dpath
   import pstrr_pkg::*;
#(
   parameter int SLOTS = 64,
   parameter int GEN_BITS = 16
) (
   input  logic                     clock,
   input  logic                     reset,
   input  ctrl_cmd_type             cmd,
   output dp_status_type            status,
   input  logic [CMD_BITS-1:0]      req_cmd,
   input  logic [SLOT_BITS-1:0]     req_slot,
   input  logic [GEN_PORT_BITS-1:0] req_generation,
   output logic [SLOT_BITS-1:0]     rsp_out_slot,
   output logic [GEN_PORT_BITS-1:0] rsp_out_generation,
   output logic                     rsp_ok,
   output logic                     rsp_yield_request
);

   localparam int SW = $clog2(SLOTS);

   logic [CMD_BITS-1:0]      cmd_ff;
   logic [SLOT_BITS-1:0]     slot_ff;
   logic [GEN_PORT_BITS-1:0] gen_ff;
   logic [SW-1:0]            cur_ff, x_ff, scan_ff;
   logic                     found_ff;
   logic [SW-1:0]            px_ff, nx_ff, pc_ff, nc_ff;
   logic [GEN_BITS-1:0]      gx_ff, gn_ff;
   logic [SLOTS-1:0]         occ_ff, ring_ff;
   logic [SLOTS-1:0]         gen_vld_ff, next_vld_ff, prev_vld_ff;

   // entries read as zero until first written
   logic [GEN_BITS-1:0] gen_mem [SLOTS];
   logic [SW-1:0]       next_mem [SLOTS];
   logic [SW-1:0]       prev_mem [SLOTS];

   logic [GEN_BITS-1:0] gen_q_ff;
   logic [SW-1:0]       next_q_ff, prev_q_ff;
   logic                gen_qv_ff, next_qv_ff, prev_qv_ff;
   logic [GEN_BITS-1:0] gen_rd;
   logic [SW-1:0]       next_rd, prev_rd;
   logic [SW-1:0]       link_ra, gen_ra;

   logic [SW-1:0] load_x;
   logic          in_range, hvalid, do_ins, do_rem, exit_occ;
   logic [GEN_BITS-1:0] gx_inc;

   logic          nw_en, pw_en;
   logic [SW-1:0] nw_addr, nw_data, pw_addr, pw_data;
   logic          alone, rem_cur, nc_eff_x, pc_eff_x;
   logic [SW-1:0] nc_eff, pc_eff;

   logic [SLOT_BITS-1:0]     res_slot;
   logic [GEN_PORT_BITS-1:0] res_gen;
   logic                     res_ok, res_yield;

   assign status.req_is_alloc = (req_cmd == CMD_ALLOC);
   assign status.scan_free    = !occ_ff[scan_ff];
   assign status.scan_last    = (scan_ff == SW'(SLOTS - 1));

   assign load_x = (req_cmd == CMD_EXIT || req_cmd == CMD_TICK) ? cur_ff : SW'(req_slot);

   // request and operand registers
   always_ff @(posedge clock) begin
      if (cmd.load) begin
         cmd_ff  <= req_cmd;
         slot_ff <= req_slot;
         gen_ff  <= req_generation;
         x_ff    <= load_x;
         scan_ff <= '0;
      end else if (cmd.scan && !status.scan_free && !status.scan_last) begin
         scan_ff <= scan_ff + SW'(1);
      end
      if (cmd.scan && status.scan_free) begin
         x_ff <= scan_ff;
      end
      if (cmd.rd2) begin
         px_ff <= prev_rd;
         nx_ff <= next_rd;
         gx_ff <= gen_rd;
      end
      if (cmd.rd3) begin
         pc_ff <= prev_rd;
         nc_ff <= next_rd;
         gn_ff <= gen_rd;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         found_ff <= 1'b0;
      end else if (cmd.load) begin
         found_ff <= 1'b0;
      end else if (cmd.scan && status.scan_free) begin
         found_ff <= 1'b1;
      end
   end

   // memory reads: first round at x, second at current and next of x
   assign link_ra = cmd.rd1 ? x_ff : cur_ff;
   assign gen_ra  = cmd.rd1 ? x_ff : next_rd;

   always_ff @(posedge clock) begin
      if (cmd.rd1 || cmd.rd2) begin
         next_q_ff  <= next_mem[link_ra];
         prev_q_ff  <= prev_mem[link_ra];
         gen_q_ff   <= gen_mem[gen_ra];
         next_qv_ff <= next_vld_ff[link_ra];
         prev_qv_ff <= prev_vld_ff[link_ra];
         gen_qv_ff  <= gen_vld_ff[gen_ra];
      end
   end

   assign next_rd = next_qv_ff ? next_q_ff : '0;
   assign prev_rd = prev_qv_ff ? prev_q_ff : '0;
   assign gen_rd  = gen_qv_ff ? gen_q_ff : '0;

   // decision
   assign in_range = 32'(slot_ff) < 32'(SLOTS);
   assign hvalid   = in_range && occ_ff[x_ff] && (gx_ff == GEN_BITS'(gen_ff));
   assign exit_occ = occ_ff[x_ff];
   assign do_ins   = (cmd_ff == CMD_RESUME) && hvalid && !ring_ff[x_ff];
   assign do_rem   = ((cmd_ff == CMD_PAUSE) && hvalid && ring_ff[x_ff])
                  || ((cmd_ff == CMD_EXIT) && exit_occ && ring_ff[x_ff]);
   assign gx_inc   = gx_ff + GEN_BITS'(1);

   // removal: neighbours of x, and the gap links of an out-of-ring current
   assign alone    = (nx_ff == x_ff);
   assign rem_cur  = (x_ff != cur_ff) && !ring_ff[cur_ff];
   assign nc_eff   = (px_ff == cur_ff) ? nx_ff : nc_ff;
   assign pc_eff   = (nx_ff == cur_ff) ? px_ff : pc_ff;
   assign nc_eff_x = (nc_eff == x_ff);
   assign pc_eff_x = (pc_eff == x_ff);

   always_comb begin
      nw_en   = 1'b0;
      pw_en   = 1'b0;
      nw_addr = '0;
      nw_data = '0;
      pw_addr = '0;
      pw_data = '0;
      if (do_rem) begin
         unique case (cmd.wr_step)
            3'd0: begin
               nw_en = !alone; nw_addr = px_ff; nw_data = nx_ff;
            end
            3'd1: begin
               pw_en = !alone; pw_addr = nx_ff; pw_data = px_ff;
            end
            3'd2: begin
               nw_en   = rem_cur && (alone || nc_eff_x);
               nw_addr = cur_ff;
               nw_data = alone ? cur_ff : nx_ff;
            end
            3'd3: begin
               pw_en   = rem_cur && (alone || pc_eff_x);
               pw_addr = cur_ff;
               pw_data = alone ? cur_ff : px_ff;
            end
            default: ;
         endcase
      end else if (do_ins) begin
         priority if (x_ff == cur_ff) begin
            if (nc_ff != cur_ff) begin
               unique case (cmd.wr_step)
                  3'd0: begin nw_en = 1'b1; nw_addr = pc_ff; nw_data = cur_ff; end
                  3'd1: begin pw_en = 1'b1; pw_addr = nc_ff; pw_data = cur_ff; end
                  default: ;
               endcase
            end
         end else if (ring_ff[cur_ff]) begin
            unique case (cmd.wr_step)
               3'd0: begin nw_en = 1'b1; nw_addr = pc_ff; nw_data = x_ff; end
               3'd1: begin pw_en = 1'b1; pw_addr = x_ff; pw_data = pc_ff; end
               3'd2: begin nw_en = 1'b1; nw_addr = x_ff; nw_data = cur_ff; end
               3'd3: begin pw_en = 1'b1; pw_addr = cur_ff; pw_data = x_ff; end
               default: ;
            endcase
         end else if (nc_ff == cur_ff) begin
            unique case (cmd.wr_step)
               3'd0: begin nw_en = 1'b1; nw_addr = x_ff; nw_data = x_ff; end
               3'd1: begin pw_en = 1'b1; pw_addr = x_ff; pw_data = x_ff; end
               3'd2: begin nw_en = 1'b1; nw_addr = cur_ff; nw_data = x_ff; end
               3'd3: begin pw_en = 1'b1; pw_addr = cur_ff; pw_data = x_ff; end
               default: ;
            endcase
         end else begin
            // current is out of the ring: fill its gap
            unique case (cmd.wr_step)
               3'd0: begin nw_en = 1'b1; nw_addr = pc_ff; nw_data = x_ff; end
               3'd1: begin pw_en = 1'b1; pw_addr = x_ff; pw_data = pc_ff; end
               3'd2: begin nw_en = 1'b1; nw_addr = x_ff; nw_data = nc_ff; end
               3'd3: begin pw_en = 1'b1; pw_addr = nc_ff; pw_data = x_ff; end
               3'd4: begin pw_en = 1'b1; pw_addr = cur_ff; pw_data = x_ff; end
               default: ;
            endcase
         end
      end
   end

   // memory writes
   always_ff @(posedge clock) begin
      if (cmd.wr && nw_en) begin
         next_mem[nw_addr] <= nw_data;
      end
      if (cmd.wr && pw_en) begin
         prev_mem[pw_addr] <= pw_data;
      end
      if (cmd.fin && cmd_ff == CMD_EXIT && exit_occ) begin
         gen_mem[x_ff] <= gx_inc;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         next_vld_ff <= '0;
         prev_vld_ff <= '0;
         gen_vld_ff  <= '0;
      end else begin
         if (cmd.wr && nw_en) begin
            next_vld_ff[nw_addr] <= 1'b1;
         end
         if (cmd.wr && pw_en) begin
            prev_vld_ff[pw_addr] <= 1'b1;
         end
         if (cmd.fin && cmd_ff == CMD_EXIT && exit_occ) begin
            gen_vld_ff[x_ff] <= 1'b1;
         end
      end
   end

   // slot flags and current pointer, committed at the end of the request
   always_ff @(posedge clock) begin
      if (reset) begin
         occ_ff  <= SLOTS'(1);
         ring_ff <= SLOTS'(1);
         cur_ff  <= '0;
      end else if (cmd.fin) begin
         if (cmd_ff == CMD_ALLOC && found_ff) begin
            occ_ff[x_ff]  <= 1'b1;
            ring_ff[x_ff] <= 1'b0;
         end
         if (do_ins) begin
            ring_ff[x_ff] <= 1'b1;
         end
         if (do_rem) begin
            ring_ff[x_ff] <= 1'b0;
         end
         if (cmd_ff == CMD_EXIT && exit_occ) begin
            occ_ff[x_ff] <= 1'b0;
         end
         if (cmd_ff == CMD_TICK) begin
            cur_ff <= nx_ff;
         end
      end
   end

   always_comb begin
      res_slot  = '0;
      res_gen   = '0;
      res_ok    = 1'b0;
      res_yield = 1'b0;
      unique case (cmd_ff)
         CMD_ALLOC: begin
            res_slot = found_ff ? SLOT_BITS'(x_ff) : SLOT_BITS'(SLOTS);
            res_gen  = found_ff ? GEN_PORT_BITS'(gx_ff) : '0;
            res_ok   = found_ff;
         end
         CMD_CHECK, CMD_RESUME, CMD_PAUSE: begin
            res_slot  = slot_ff;
            res_gen   = gen_ff;
            res_ok    = hvalid;
            res_yield = (cmd_ff == CMD_PAUSE) && hvalid && ring_ff[x_ff]
                     && (x_ff == cur_ff);
         end
         CMD_EXIT: begin
            res_slot  = SLOT_BITS'(x_ff);
            res_gen   = exit_occ ? GEN_PORT_BITS'(gx_inc) : GEN_PORT_BITS'(gx_ff);
            res_ok    = exit_occ;
            res_yield = exit_occ;
         end
         CMD_TICK: begin
            res_slot = SLOT_BITS'(nx_ff);
            res_gen  = GEN_PORT_BITS'(gn_ff);
            res_ok   = ring_ff[nx_ff];
         end
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (cmd.fin) begin
         rsp_out_slot       <= res_slot;
         rsp_out_generation <= res_gen;
         rsp_ok             <= res_ok;
         rsp_yield_request  <= res_yield;
      end
   end

endmodule

@@ rtl/process_slot_table_round_robin.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// process_slot_table_round_robin
// Process slot table with generation handles and a doubly linked run ring.
// ----------------------------------------------------------------------------
//  channel   ports                                   direction
//  request   req_valid/req_stall, cmd slot gen       in
//  response  rsp_valid/rsp_stall, slot gen ok yield  out
//
//  From acceptance to rsp_valid a request passes through two memory read
//  rounds, a capture state, five single-port link write steps and the
//  commit; allocation first scans the slots in order from slot 0 up to the
//  first free one or the last slot.
//  One request at a time: req_stall is high from acceptance until the
//  response is taken. A stalled response holds its fields.
//  Synchronous reset leaves slot 0 live, in the ring and current.
// ----------------------------------------------------------------------------
module process_slot_table_round_robin
   import pstrr_pkg::*;
#(
   parameter int SLOTS = 64,
   parameter int GEN_BITS = 16
) (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     req_valid,
   output logic                     req_stall,
   input  logic [CMD_BITS-1:0]      req_cmd,
   input  logic [SLOT_BITS-1:0]     req_slot,
   input  logic [GEN_PORT_BITS-1:0] req_generation,
   output logic                     rsp_valid,
   input  logic                     rsp_stall,
   output logic [SLOT_BITS-1:0]     rsp_out_slot,
   output logic [GEN_PORT_BITS-1:0] rsp_out_generation,
   output logic                     rsp_ok,
   output logic                     rsp_yield_request
);

   ctrl_cmd_type  cmd;
   dp_status_type status;

   pstrr_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .status    (status),
      .cmd       (cmd)
   );

   pstrr_dpath #(
      .SLOTS    (SLOTS),
      .GEN_BITS (GEN_BITS)
   ) u_dpath (
      .clock              (clock),
      .reset              (reset),
      .cmd                (cmd),
      .status             (status),
      .req_cmd            (req_cmd),
      .req_slot           (req_slot),
      .req_generation     (req_generation),
      .rsp_out_slot       (rsp_out_slot),
      .rsp_out_generation (rsp_out_generation),
      .rsp_ok             (rsp_ok),
      .rsp_yield_request  (rsp_yield_request)
   );

endmodule

@@ rtl/pstrr_checker.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pstrr_checker
// Port-level checks on the slot table's request and response channels.
// ----------------------------------------------------------------------------
module pstrr_checker
   import pstrr_pkg::*;
(
   input logic                     clock,
   input logic                     reset,
   input logic                     req_valid,
   input logic                     req_stall,
   input logic                     rsp_valid,
   input logic                     rsp_stall,
   input logic [SLOT_BITS-1:0]     rsp_out_slot,
   input logic [GEN_PORT_BITS-1:0] rsp_out_generation,
   input logic                     rsp_ok,
   input logic                     rsp_yield_request
);

   // a held response keeps its fields
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_out_slot)
         && $stable(rsp_out_generation) && $stable(rsp_ok)
         && $stable(rsp_yield_request))
      else $error("stalled response changed");

   // one request in flight: busy right after acceptance
   assert property (@(posedge clock) disable iff (reset)
      req_valid && !req_stall |=> req_stall && !rsp_valid)
      else $error("request accepted while busy");

   // a yield only follows a pause or exit that took effect
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_yield_request |-> rsp_ok)
      else $error("yield without effect");

   // no new request is taken while a response waits
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> req_stall)
      else $error("request taken during response");

endmodule

bind process_slot_table_round_robin pstrr_checker u_pstrr_checker (
   .clock              (clock),
   .reset              (reset),
   .req_valid          (req_valid),
   .req_stall          (req_stall),
   .rsp_valid          (rsp_valid),
   .rsp_stall          (rsp_stall),
   .rsp_out_slot       (rsp_out_slot),
   .rsp_out_generation (rsp_out_generation),
   .rsp_ok             (rsp_ok),
   .rsp_yield_request  (rsp_yield_request)
);

@@ dv/testbench.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench
// Drives scheduler commands into the process slot table, predicts every
// response with a behavioural copy of the slot table and run ring, and
// compares each response field by field under random idling on both sides.
// ----------------------------------------------------------------------------

class slot_table_scoreboard;
   localparam int NSLOT = 64;

   bit        occupied [NSLOT];
   bit [15:0] gen_count [NSLOT];
   bit        in_ring [NSLOT];
   bit [5:0]  next_link [NSLOT];
   bit [5:0]  prev_link [NSLOT];
   bit [5:0]  current;

   bit [6:0]  exp_slot [$];
   bit [15:0] exp_gen [$];
   bit        exp_ok [$];
   bit        exp_yield [$];
   int        errors;
   int        checked;

   function new();
      for (int i = 0; i < NSLOT; i++) begin
         occupied[i] = 0;
         gen_count[i] = 0;
         in_ring[i] = 0;
         next_link[i] = 0;
         prev_link[i] = 0;
      end
      occupied[0] = 1;
      in_ring[0] = 1;
      current = 0;
      errors = 0;
      checked = 0;
   endfunction

   function void unlink(bit [5:0] x);
      bit [5:0] p, n, c;
      bit alone;
      p = prev_link[x];
      n = next_link[x];
      c = current;
      alone = (n == x);
      in_ring[x] = 0;
      if (!alone) begin
         next_link[p] = n;
         prev_link[n] = p;
      end
      // a current slot outside the ring keeps tracking the gap it left
      if (x != c && !in_ring[c]) begin
         if (alone) begin
            next_link[c] = c;
            prev_link[c] = c;
         end else begin
            if (next_link[c] == x) next_link[c] = n;
            if (prev_link[c] == x) prev_link[c] = p;
         end
      end
   endfunction

   function void link_in(bit [5:0] x);
      bit [5:0] p, n, c;
      c = current;
      p = prev_link[c];
      n = next_link[c];
      if (x == c) begin
         if (n != c) begin
            next_link[p] = c;
            prev_link[n] = c;
         end
      end else if (in_ring[c]) begin
         next_link[p] = x;
         prev_link[x] = p;
         next_link[x] = c;
         prev_link[c] = x;
      end else if (n == c) begin
         next_link[x] = x;
         prev_link[x] = x;
         next_link[c] = x;
         prev_link[c] = x;
      end else begin
         next_link[p] = x;
         prev_link[x] = p;
         next_link[x] = n;
         prev_link[n] = x;
         prev_link[c] = x;
      end
      in_ring[x] = 1;
   endfunction

   function void note_request(bit [2:0] cmd, bit [6:0] slot, bit [15:0] gen);
      bit [6:0]  o_slot;
      bit [15:0] o_gen;
      bit        o_ok, o_yield, valid;
      bit [5:0]  s;
      o_slot = 0;
      o_gen = 0;
      o_ok = 0;
      o_yield = 0;
      valid = 0;
      s = slot[5:0];
      if (slot < NSLOT) valid = occupied[s] && gen_count[s] == gen;
      case (cmd)
         pstrr_pkg::CMD_ALLOC: begin
            o_slot = 7'(NSLOT);
            for (int i = 0; i < NSLOT; i++) begin
               if (!occupied[i]) begin
                  occupied[i] = 1;
                  in_ring[i] = 0;
                  o_slot = 7'(i);
                  o_gen = gen_count[i];
                  o_ok = 1;
                  break;
               end
            end
         end
         pstrr_pkg::CMD_CHECK, pstrr_pkg::CMD_RESUME, pstrr_pkg::CMD_PAUSE: begin
            o_slot = slot;
            o_gen = gen;
            o_ok = valid;
            if (valid && cmd == pstrr_pkg::CMD_RESUME && !in_ring[s]) begin
               link_in(s);
            end else if (valid && cmd == pstrr_pkg::CMD_PAUSE && in_ring[s]) begin
               if (s == current) o_yield = 1;
               unlink(s);
            end
         end
         pstrr_pkg::CMD_EXIT: begin
            s = current;
            if (occupied[s]) begin
               occupied[s] = 0;
               gen_count[s] = gen_count[s] + 16'd1;
               if (in_ring[s]) unlink(s);
               o_ok = 1;
               o_yield = 1;
            end
            o_slot = 7'(s);
            o_gen = gen_count[s];
         end
         pstrr_pkg::CMD_TICK: begin
            current = next_link[current];
            o_slot = 7'(current);
            o_gen = gen_count[current];
            o_ok = in_ring[current];
         end
         default: ;
      endcase
      exp_slot.push_back(o_slot);
      exp_gen.push_back(o_gen);
      exp_ok.push_back(o_ok);
      exp_yield.push_back(o_yield);
   endfunction

   function void check_response(bit [6:0] slot, bit [15:0] gen, bit ok, bit yld);
      bit [6:0]  e_slot;
      bit [15:0] e_gen;
      bit        e_ok, e_yield;
      if (exp_slot.size() == 0) begin
         $error("response with no request outstanding: slot %0d", slot);
         errors++;
         return;
      end
      e_slot = exp_slot.pop_front();
      e_gen = exp_gen.pop_front();
      e_ok = exp_ok.pop_front();
      e_yield = exp_yield.pop_front();
      checked++;
      if (slot !== e_slot) begin
         $error("out_slot: expected %0d, got %0d", e_slot, slot);
         errors++;
      end
      if (gen !== e_gen) begin
         $error("out_generation: expected %0d, got %0d", e_gen, gen);
         errors++;
      end
      if (ok !== e_ok) begin
         $error("ok: expected %0d, got %0d", e_ok, ok);
         errors++;
      end
      if (yld !== e_yield) begin
         $error("yield_request: expected %0d, got %0d", e_yield, yld);
         errors++;
      end
   endfunction

   function int pending();
      return exp_slot.size();
   endfunction
endclass

module testbench;
   import pstrr_pkg::*;

   logic                     clock;
   logic                     reset;
   logic                     req_valid;
   logic                     req_stall;
   logic [CMD_BITS-1:0]      req_cmd;
   logic [SLOT_BITS-1:0]     req_slot;
   logic [GEN_PORT_BITS-1:0] req_generation;
   logic                     rsp_valid;
   logic                     rsp_stall;
   logic [SLOT_BITS-1:0]     rsp_out_slot;
   logic [GEN_PORT_BITS-1:0] rsp_out_generation;
   logic                     rsp_ok;
   logic                     rsp_yield_request;

   slot_table_scoreboard slot_table;
   int send_idle_pct;
   int recv_idle_pct;
   bit hold_off;
   int cmd_seen [8];

   process_slot_table_round_robin i_dut (
      .clock              (clock),
      .reset              (reset),
      .req_valid          (req_valid),
      .req_stall          (req_stall),
      .req_cmd            (req_cmd),
      .req_slot           (req_slot),
      .req_generation     (req_generation),
      .rsp_valid          (rsp_valid),
      .rsp_stall          (rsp_stall),
      .rsp_out_slot       (rsp_out_slot),
      .rsp_out_generation (rsp_out_generation),
      .rsp_ok             (rsp_ok),
      .rsp_yield_request  (rsp_yield_request)
   );

   initial begin
      clock = 0;
      forever #6 clock = ~clock;
   end

   initial begin
      #20ms;
      $display("timeout");
      $display("CHECK FAILED");
      $finish;
   end

   // receiver side: random stall, plus a long hold-off when asked
   always @(negedge clock) begin
      if (reset) begin
         rsp_stall <= 0;
      end else begin
         rsp_stall <= hold_off || ($urandom_range(99) < recv_idle_pct);
      end
   end

   always @(posedge clock) begin
      if (!reset && rsp_valid && !rsp_stall)
         slot_table.check_response(rsp_out_slot, rsp_out_generation, rsp_ok,
                                   rsp_yield_request);
   end

   // driven at the falling edge; back-to-back requests keep valid high
   task automatic send_request(bit [2:0] cmd, bit [6:0] slot, bit [15:0] gen);
      while ($urandom_range(99) < send_idle_pct) @(negedge clock);
      req_valid = 1;
      req_cmd = cmd;
      req_slot = slot;
      req_generation = gen;
      do @(posedge clock); while (req_stall);
      slot_table.note_request(cmd, slot, gen);
      cmd_seen[cmd]++;
      @(negedge clock);
      req_valid = 0;
   endtask

   task automatic drain();
      while (slot_table.pending() != 0) @(negedge clock);
   endtask

   // mostly well-formed handles taken from the predicted table
   task automatic random_request();
      bit [2:0]  cmd;
      bit [6:0]  slot;
      bit [15:0] gen;
      int        r;
      r = $urandom_range(99);
      if (r < 16) cmd = CMD_ALLOC;
      else if (r < 28) cmd = CMD_CHECK;
      else if (r < 50) cmd = CMD_RESUME;
      else if (r < 66) cmd = CMD_PAUSE;
      else if (r < 76) cmd = CMD_EXIT;
      else if (r < 97) cmd = CMD_TICK;
      else cmd = 3'($urandom_range(7, 6));
      r = $urandom_range(99);
      if (r < 75) begin
         slot = 7'($urandom_range(63));
         gen = slot_table.gen_count[slot[5:0]];
      end else if (r < 85) begin
         slot = 7'($urandom_range(63));
         gen = 16'($urandom);
      end else if (r < 92) begin
         slot = 7'd64;
         gen = 16'($urandom);
      end else begin
         slot = 7'($urandom);
         gen = 16'($urandom);
      end
      send_request(cmd, slot, gen);
   endtask

   initial begin
      reset = 1;
      req_valid = 0;
      req_cmd = CMD_ALLOC;
      req_slot = 0;
      req_generation = 0;
      hold_off = 0;
      send_idle_pct = 0;
      recv_idle_pct = 0;
      slot_table = new();
      repeat (8) @(posedge clock);
      @(negedge clock);
      reset <= 0;

      // directed part
      send_request(CMD_CHECK, 0, 0);
      send_request(CMD_CHECK, 64, 16'hFFFF);
      send_request(CMD_CHECK, 7'h7F, 16'hFFFF);
      send_request(CMD_ALLOC, 0, 0);
      send_request(CMD_ALLOC, 0, 0);
      send_request(CMD_RESUME, 1, 0);
      send_request(CMD_RESUME, 1, 0);          // already in the ring
      send_request(CMD_RESUME, 2, 16'h0001);   // stale handle
      send_request(CMD_PAUSE, 2, 0);           // not in the ring
      send_request(CMD_TICK, 0, 0);
      send_request(CMD_PAUSE, 1, 0);           // current leaves
      send_request(CMD_RESUME, 2, 0);          // fills the gap
      send_request(CMD_TICK, 0, 0);
      send_request(CMD_EXIT, 0, 0);
      send_request(CMD_EXIT, 0, 0);            // current already free
      send_request(CMD_TICK, 0, 0);
      send_request(3'd6, 7'h55, 16'hAAAA);
      send_request(3'd7, 7'h2A, 16'h5555);
      send_request(CMD_PAUSE, 0, 0);
      send_request(CMD_EXIT, 0, 0);
      send_request(CMD_TICK, 0, 0);
      drain();

      // fill every slot so allocation fails
      for (int i = 0; i < 66; i++) send_request(CMD_ALLOC, 0, 0);

      // generation wrap on one slot: exit it 65536 times would be too slow,
      // so cycle exits of whatever is current and rely on random coverage
      send_idle_pct = 21;
      recv_idle_pct = 81;
      for (int i = 0; i < 300; i++) random_request();
      send_idle_pct = 81;
      recv_idle_pct = 21;
      for (int i = 0; i < 300; i++) random_request();

      // long receiver hold-off while requests keep coming
      hold_off = 1;
      fork
         begin
            repeat (400) @(negedge clock);
            hold_off = 0;
         end
         for (int i = 0; i < 5; i++) random_request();
      join
      drain();

      send_idle_pct = 0;
      recv_idle_pct = 0;
      for (int i = 0; i < 300; i++) random_request();

      drain();
      repeat (100) @(negedge clock);
      $display("covered %0d responses: alloc %0d check %0d resume %0d pause %0d",
               slot_table.checked, cmd_seen[0], cmd_seen[1], cmd_seen[2],
               cmd_seen[3]);
      $display("exit %0d tick %0d unknown %0d", cmd_seen[4], cmd_seen[5],
               cmd_seen[6] + cmd_seen[7]);
      if (slot_table.errors == 0 && slot_table.pending() == 0) begin
         $display("CHECK OK");
      end else begin
         $display("CHECK FAILED");
      end
      $finish;
   end
endmodule
